### rtl/idpool_pkg.sv
// ----------------------------------------------------------------------------
// idpool_pkg
// Types and codes shared by the ID pool allocator and its test.
// ----------------------------------------------------------------------------
package idpool_pkg;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 11;
  localparam int STATUS_W = 3;
  localparam int CFG_W    = 11;

  // request kinds
  localparam logic [KIND_W-1:0] KIND_ALLOC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_RELEASED = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_INVALID  = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_ALREADY  = 3'd4;

  localparam logic [CFG_W-1:0] POOL_SIZE_RESET = 11'd1024;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   id;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;
  } rsp_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

### rtl/id_pool_allocator.sv
// ----------------------------------------------------------------------------
// id_pool_allocator
// Hands out IDs 1..pool size (capped at MAX_IDS): allocate, query and release requests, with
// released IDs recycled oldest first through a FIFO in RAM.
// ----------------------------------------------------------------------------
//
//   channel  ports                        handshake
//   -------  ---------------------------  -----------------------------
//   request  in_valid in_ready in_data    valid/ready, req_t
//   result   out_valid out_ready out_data valid/ready, rsp_t, one per item
//   config   cfg_we cfg_wdata             write on cfg_we, no wait
//
// For each item the accept edge issues reads of the FIFO head entry and the
// released flag of the item's ID; S_EXEC then decides and writes back. With
// a single write port per RAM, no new item is taken until the last is done.
// The result sits in an output register; a stalled result holds the block
// in S_EXEC, and a new item is taken while a result waits.
// Reset is immediate: a flag is only read for an issued ID, and issuing a
// fresh ID clears its flag, so the flag RAM needs no clearing pass.
// ----------------------------------------------------------------------------
module id_pool_allocator
  import idpool_pkg::*;
#(
  parameter int MAX_IDS = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_ready,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output rsp_t             out_data
);

  localparam int PTR_W   = $clog2(MAX_IDS);
  localparam int CNT_W   = $clog2(MAX_IDS + 1);
  localparam int FLAG_AW = $clog2(MAX_IDS + 1);
  localparam int FRESH_W = (MAX_IDS >= 2047) ? 12 : $clog2(MAX_IDS + 2);

  state_t             state_r, state_nxt;
  logic [CFG_W-1:0]   pool_size_r;
  logic [FRESH_W-1:0] next_fresh_r, next_fresh_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  req_t               req_r;
  logic               out_valid_r, out_valid_nxt;
  rsp_t               out_data_r, out_data_nxt;

  logic               accept;
  logic               done;
  logic               issued;
  logic [31:0]        limit;

  logic               fifo_we;
  logic [ID_W-1:0]    fifo_rd_data;
  logic               flag_we;
  logic [FLAG_AW-1:0] flag_wr_addr;
  logic               flag_wr_data;
  logic               flag_rd_data;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign done      = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign limit  = (32'(pool_size_r) > MAX_IDS) ? 32'(MAX_IDS) : 32'(pool_size_r);
  assign issued = (req_r.id != '0) && (32'(req_r.id) <= MAX_IDS)
                  && (32'(req_r.id) < 32'(next_fresh_r));

  idpool_ram #(
    .WIDTH (ID_W),
    .DEPTH (MAX_IDS)
  ) u_fifo_ram (
    .clk     (clk),
    .wr_en   (fifo_we),
    .wr_addr (tail_r),
    .wr_data (req_r.id),
    .rd_en   (accept),
    .rd_addr (head_r),
    .rd_data (fifo_rd_data)
  );

  idpool_ram #(
    .WIDTH (1),
    .DEPTH (MAX_IDS + 1)
  ) u_flag_ram (
    .clk     (clk),
    .wr_en   (flag_we),
    .wr_addr (flag_wr_addr),
    .wr_data (flag_wr_data),
    .rd_en   (accept),
    .rd_addr (FLAG_AW'(in_data.id)),
    .rd_data (flag_rd_data)
  );

  always_comb begin
    state_nxt      = state_r;
    next_fresh_nxt = next_fresh_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    fifo_we        = 1'b0;
    flag_we        = 1'b0;
    flag_wr_addr   = FLAG_AW'(req_r.id);
    flag_wr_data   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (done) begin
          state_nxt              = S_IDLE;
          out_valid_nxt          = 1'b1;
          out_data_nxt.status    = STAT_INVALID;
          out_data_nxt.result_id = req_r.id;
          case (req_r.kind)
            KIND_ALLOC: begin
              if (count_r != '0) begin
                // recycle the oldest released ID
                out_data_nxt.status    = STAT_OK;
                out_data_nxt.result_id = fifo_rd_data;
                head_nxt  = (32'(head_r) == MAX_IDS - 1) ? '0 : head_r + 1'b1;
                count_nxt = count_r - 1'b1;
                flag_we      = 1'b1;
                flag_wr_addr = FLAG_AW'(fifo_rd_data);
              end else if (32'(next_fresh_r) > limit) begin
                out_data_nxt.status    = STAT_FULL;
                out_data_nxt.result_id = '0;
              end else begin
                // fresh ID: clear its flag as it is issued
                out_data_nxt.status    = STAT_OK;
                out_data_nxt.result_id = ID_W'(next_fresh_r);
                next_fresh_nxt = next_fresh_r + 1'b1;
                flag_we        = 1'b1;
                flag_wr_addr   = FLAG_AW'(next_fresh_r);
              end
            end
            KIND_QUERY: begin
              if (!issued) begin
                out_data_nxt.status = STAT_INVALID;
              end else if (flag_rd_data) begin
                out_data_nxt.status = STAT_RELEASED;
              end else begin
                out_data_nxt.status = STAT_OK;
              end
            end
            KIND_RELEASE: begin
              if (!issued) begin
                out_data_nxt.status = STAT_INVALID;
              end else if (flag_rd_data || (32'(count_r) >= MAX_IDS)) begin
                out_data_nxt.status = STAT_ALREADY;
              end else begin
                out_data_nxt.status = STAT_OK;
                fifo_we      = 1'b1;
                tail_nxt     = (32'(tail_r) == MAX_IDS - 1) ? '0 : tail_r + 1'b1;
                count_nxt    = count_r + 1'b1;
                flag_we      = 1'b1;
                flag_wr_data = 1'b1;
              end
            end
            default: begin
              out_data_nxt.status = STAT_INVALID;
            end
          endcase
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pool_size_r  <= POOL_SIZE_RESET;
      next_fresh_r <= FRESH_W'(1);
      head_r       <= '0;
      tail_r       <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      next_fresh_r <= next_fresh_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        pool_size_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r <= in_data;
    end
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/idpool_ram.sv
// ----------------------------------------------------------------------------
// idpool_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module idpool_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // hold read data while no read is issued
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### test/id_pool_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// id_pool_allocator_test
// Drives allocate, query and release requests through the ID pool allocator
// and checks every response against a behavioral copy of the free list or a
// pinned value; a directed table first, then random phases, several pool sizes.
// ----------------------------------------------------------------------------
module id_pool_allocator_test;
  import idpool_pkg::*;

  localparam int MAX_IDS     = 1024;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  // kind code the block does not know
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  typedef enum int {
    MIX_DEEP,
    MIX_FILL
  } mix_t;

  typedef enum int {
    PACE_RECV_SLOW,
    PACE_SEND_SLOW,
    PACE_FULL
  } pace_t;

  typedef struct packed {
    logic pinned;
    rsp_t rsp;
  } pinned_rsp_t;

  typedef struct {
    bit               cfg_row;
    logic [CFG_W-1:0] cfg_value;
    req_t             req;
    bit               pinned;
    rsp_t             rsp;
  } step_row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  req_t             in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  rsp_t             out_data;

  // allocator shadow state
  logic [CFG_W-1:0] pool_limit_cfg = POOL_SIZE_RESET;
  int               fresh_next = 1;
  logic [ID_W-1:0]  recycle_q[$];
  bit               released_map[0:MAX_IDS];

  rsp_t             grant_q[$];
  pinned_rsp_t      pinned_q[$];
  step_row_t        steps[$];

  int               mismatch_count = 0;
  int               cycle_count = 0;
  int               rand_sent = 0;
  int               hold_req_cnt = 0;
  int               hold_seen_cnt = 0;
  int               hold_left = 0;
  pace_t            pace = PACE_RECV_SLOW;

  id_pool_allocator #(
    .MAX_IDS(MAX_IDS)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always #1 clk = ~clk;

  function automatic rsp_t predict_grant(req_t r);
    rsp_t res;
    int   lim;
    bit   known;
    res.status    = STAT_INVALID;
    res.result_id = r.id;
    lim   = (int'(pool_limit_cfg) > MAX_IDS) ? MAX_IDS : int'(pool_limit_cfg);
    known = (r.id != 0) && (int'(r.id) <= MAX_IDS) && (int'(r.id) < fresh_next);
    case (r.kind)
      KIND_ALLOC: begin
        if (recycle_q.size() > 0) begin
          res.result_id = recycle_q.pop_front();
          released_map[res.result_id] = 1'b0;
          res.status = STAT_OK;
        end else if (fresh_next > lim) begin
          res.result_id = '0;
          res.status    = STAT_FULL;
        end else begin
          res.result_id = ID_W'(fresh_next);
          res.status    = STAT_OK;
          fresh_next++;
        end
      end
      KIND_QUERY: begin
        if (!known) res.status = STAT_INVALID;
        else if (released_map[r.id]) res.status = STAT_RELEASED;
        else res.status = STAT_OK;
      end
      KIND_RELEASE: begin
        if (!known) begin
          res.status = STAT_INVALID;
        end else if (released_map[r.id] || recycle_q.size() >= MAX_IDS) begin
          res.status = STAT_ALREADY;
        end else begin
          recycle_q.insert(recycle_q.size(), r.id);
          released_map[r.id] = 1'b1;
          res.status = STAT_OK;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic int send_idle_pct();
    case (pace)
      PACE_RECV_SLOW: return 17;
      PACE_SEND_SLOW: return 62;
      default:        return 0;
    endcase
  endfunction

  function automatic int recv_idle_pct();
    case (pace)
      PACE_RECV_SLOW: return 62;
      PACE_SEND_SLOW: return 17;
      default:        return 0;
    endcase
  endfunction

  function automatic req_t pick_req(mix_t mix);
    req_t r;
    int   roll;
    int   top;
    int   pick;
    r.kind = KIND_ALLOC;
    r.id   = ID_W'($urandom);
    top    = fresh_next - 1;
    roll   = $urandom_range(99);
    if (mix == MIX_FILL) roll = (roll < 96) ? 0 : ((roll < 98) ? 50 : 70);
    if (roll < 40) begin
      // allocate; id carries noise
    end else if (roll < 82) begin
      r.kind = (roll < 62) ? KIND_QUERY : KIND_RELEASE;
      if (recycle_q.size() > 0 && $urandom_range(3) == 0)
        r.id = recycle_q[$urandom_range(recycle_q.size() - 1)];
      else if (top >= 1)
        r.id = ID_W'($urandom_range(top, 1));
    end else if (roll < 90) begin
      r.kind = $urandom_range(1) ? KIND_QUERY : KIND_RELEASE;
      pick = $urandom_range(4);
      case (pick)
        0:       r.id = '0;
        1:       r.id = ID_W'(fresh_next);
        2:       r.id = ID_W'(MAX_IDS);
        3:       r.id = ID_W'(top);
        default: r.id = ID_W'($urandom);
      endcase
    end else begin
      r = req_t'($urandom);
      if ($urandom_range(1)) r.kind = KIND_UNKNOWN;
    end
    return r;
  endfunction

  function automatic void add_req(logic [KIND_W-1:0] k, int id);
    step_row_t row;
    row.cfg_row   = 1'b0;
    row.cfg_value = '0;
    row.req.kind  = k;
    row.req.id    = ID_W'(id);
    row.pinned    = 1'b0;
    row.rsp       = '0;
    steps.insert(steps.size(), row);
  endfunction

  function automatic void add_pin(logic [KIND_W-1:0] k, int id,
                                  logic [STATUS_W-1:0] st, int rid);
    step_row_t row;
    row.cfg_row       = 1'b0;
    row.cfg_value     = '0;
    row.req.kind      = k;
    row.req.id        = ID_W'(id);
    row.pinned        = 1'b1;
    row.rsp.status    = st;
    row.rsp.result_id = ID_W'(rid);
    steps.insert(steps.size(), row);
  endfunction

  function automatic void add_cfg(int v);
    step_row_t row;
    row.cfg_row   = 1'b1;
    row.cfg_value = CFG_W'(v);
    row.req       = '0;
    row.pinned    = 1'b0;
    row.rsp       = '0;
    steps.insert(steps.size(), row);
  endfunction

  task automatic flag_mismatch(string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Returns at the edge where the item is taken; valid stays up for the next one.
  task automatic send_req(req_t r, bit pin, rsp_t want);
    pinned_rsp_t p;
    p.pinned = pin;
    p.rsp    = want;
    pinned_q.insert(pinned_q.size(), p);
    while ($urandom_range(99) < send_idle_pct()) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_settled();
    in_valid <= 1'b0;
    do @(posedge clk); while (grant_q.size() != 0 || pinned_q.size() != 0);
  endtask

  task automatic load_pool_size(logic [CFG_W-1:0] v);
    wait_settled();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic [CFG_W-1:0] size, mix_t mix, int count, bit hold);
    int n;
    n = 0;
    load_pool_size(size);
    if (hold) hold_req_cnt <= hold_req_cnt + 1;
    while (n < count || (mix == MIX_FILL && fresh_next <= MAX_IDS)) begin
      pace = (rand_sent < 400) ? PACE_RECV_SLOW :
             (rand_sent < 800) ? PACE_SEND_SLOW : PACE_FULL;
      // pause the sender once mid-fill until the pipe is empty
      if (mix == MIX_FILL && n == 300) wait_settled();
      send_req(pick_req(mix), 1'b0, '0);
      n++;
      rand_sent++;
    end
  endtask

  // request accept: predict and queue the response
  always @(posedge clk) begin
    pinned_rsp_t p;
    rsp_t        got;
    if (rst_n && in_valid && in_ready) begin
      got = predict_grant(in_data);
      if (pinned_q.size() == 0) begin
        flag_mismatch("request accepted that was never offered");
      end else begin
        p = pinned_q.pop_front();
        grant_q.insert(grant_q.size(), p.pinned ? p.rsp : got);
      end
    end
  end

  always @(posedge clk) begin
    if (cfg_we) pool_limit_cfg = cfg_wdata;
  end

  // response accept: compare with the oldest expectation
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n && out_valid && out_ready) begin
      if (grant_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected response status %0d id %0d",
                                out_data.status, out_data.result_id));
      end else begin
        want = grant_q.pop_front();
        if (out_data.status !== want.status)
          flag_mismatch($sformatf("status %0d, want %0d (id want %0d)",
                                  out_data.status, want.status, want.result_id));
        if (out_data.result_id !== want.result_id)
          flag_mismatch($sformatf("result_id %0d, want %0d",
                                  out_data.result_id, want.result_id));
      end
    end
  end

  // receiver: random back-pressure plus requested long hold-offs
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_req_cnt != hold_seen_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left     <= HOLD_CYCLES;
      out_ready     <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct());
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fresh pool, default size
    add_pin(KIND_QUERY, 0, STAT_INVALID, 0);
    add_pin(KIND_RELEASE, 1, STAT_INVALID, 1);
    add_pin(KIND_QUERY, 2047, STAT_INVALID, 2047);
    add_pin(KIND_UNKNOWN, 1024, STAT_INVALID, 1024);
    add_pin(KIND_ALLOC, 2047, STAT_OK, 1);
    add_pin(KIND_ALLOC, 0, STAT_OK, 2);
    add_pin(KIND_ALLOC, 0, STAT_OK, 3);
    add_pin(KIND_QUERY, 3, STAT_OK, 3);
    add_pin(KIND_QUERY, 4, STAT_INVALID, 4);
    add_pin(KIND_RELEASE, 2, STAT_OK, 2);
    add_pin(KIND_QUERY, 2, STAT_RELEASED, 2);
    add_pin(KIND_RELEASE, 2, STAT_ALREADY, 2);
    add_req(KIND_RELEASE, 1);
    add_req(KIND_ALLOC, 0);
    add_req(KIND_ALLOC, 0);
    // zero size: only recycled IDs come out
    add_cfg(0);
    add_pin(KIND_ALLOC, 0, STAT_FULL, 0);
    add_req(KIND_RELEASE, 3);
    add_req(KIND_ALLOC, 0);
    add_cfg(1);
    add_pin(KIND_ALLOC, 0, STAT_FULL, 0);
    // oversize saturates
    add_cfg(2047);
    add_req(KIND_ALLOC, 0);
    // shrink below issued IDs: they stay valid and recycle
    add_cfg(3);
    add_pin(KIND_ALLOC, 0, STAT_FULL, 0);
    add_req(KIND_RELEASE, 4);
    add_req(KIND_ALLOC, 0);
    add_pin(KIND_RELEASE, 0, STAT_INVALID, 0);
    add_pin(KIND_RELEASE, 2047, STAT_INVALID, 2047);

    foreach (steps[i]) begin
      if (steps[i].cfg_row) load_pool_size(steps[i].cfg_value);
      else send_req(steps[i].req, steps[i].pinned, steps[i].rsp);
    end

    run_phase(11'd1024, MIX_DEEP, 24, 1'b1);
    run_phase(11'd1, MIX_DEEP, 12, 1'b0);
    run_phase(11'd0, MIX_DEEP, 8, 1'b0);
    run_phase(11'd2047, MIX_FILL, 40, 1'b0);
    run_phase(11'd300, MIX_DEEP, 20, 1'b1);
    run_phase(11'd1024, MIX_DEEP, 12, 1'b0);

    wait_settled();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && grant_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
